FILE: hdl/wfp_pkg.sv
package wfp_pkg;

    // Field and register widths
    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 23;
    localparam int LINE_W      = 32;
    localparam int CFG_LEN_W   = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;

    // Default sizing
    localparam int MAX_KGRAM_DEF  = 16;
    localparam int MAX_WINDOW_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KGRAM_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_WEIGHT = 2'd2;

    // Configuration reset values
    localparam logic [CFG_LEN_W-1:0]  KGRAM_RESET  = 5'd5;
    localparam logic [CFG_LEN_W-1:0]  WINDOW_RESET = 5'd4;
    localparam logic [CFG_DATA_W-1:0] DROP_RESET   = 23'd2449879;

    // Hash arithmetic
    localparam logic [HASH_W-1:0] HASH_MOD  = 23'd6999997;
    localparam logic [HASH_W-1:0] HASH_NONE = '1;
    localparam logic [31:0]       HASH_BASE = 32'd257;
    // 256 * modulus keeps the rolled value positive after the subtract
    localparam logic [31:0]       SUB_BIAS  = {9'd0, HASH_MOD} << 8;
    localparam int                RECIP_SHIFT = 40;
    localparam int                RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] HASH_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / {41'd0, HASH_MOD});
    localparam int                QUO_W = 10;
    localparam int                REM_W = HASH_W + 1;

    // Line counting
    localparam logic [BYTE_W-1:0] NEWLINE  = 8'h0A;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [LINE_W-1:0] LINE_ONE = 32'd1;

    // One classified byte on its way from front to back end
    typedef struct packed {
        logic [LINE_W-1:0] line_no;
        logic              doc_start;
        logic              fill;
        logic              hash_valid;
        logic [BYTE_W-1:0] text_byte;
        logic [BYTE_W-1:0] old_byte;
    } t_item;

endpackage

FILE: hdl/wfp_ram.sv
module wfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port, read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: hdl/wfp_queue.sv
module wfp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wfp_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output wfp_pkg::t_item o_item,
    output logic          o_empty
);

    import wfp_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [QW-1:0]  r_wr;
    logic [QW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [QW-1:0]  n_wr;
    logic [QW-1:0]  n_rd;
    logic [CW-1:0]  n_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: hdl/wfp_front.sv
module wfp_front #(
    parameter int MAX_KGRAM = wfp_pkg::MAX_KGRAM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [wfp_pkg::BYTE_W-1:0]         i_text_byte,
    input  logic                               i_doc_start,
    input  logic [$clog2(MAX_KGRAM + 1)-1:0]   i_kgram_len,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output wfp_pkg::t_item                     o_item
);

    import wfp_pkg::*;

    localparam int KW  = $clog2(MAX_KGRAM + 1);
    localparam int HPW = (MAX_KGRAM > 1) ? $clog2(MAX_KGRAM) : 1;
    localparam int AW  = KW + 1;

    logic [KW-1:0]     r_bs;
    logic [HPW-1:0]    r_hp;
    logic [LINE_W-1:0] r_line;
    logic              r_stg_valid;
    t_item             r_stg;

    logic [KW-1:0]     n_bs;
    logic [HPW-1:0]    n_hp;
    logic [LINE_W-1:0] n_line;
    logic              n_stg_valid;
    t_item             n_stg;

    logic              accept;
    logic [KW-1:0]     bs_eff;
    logic [HPW-1:0]    hp_eff;
    logic [LINE_W-1:0] line_eff;
    logic              fill;
    logic [AW-1:0]     old_sum;
    logic [HPW-1:0]    old_addr;
    logic [BYTE_W-1:0] ram_rdata;

    assign o_stall  = r_stg_valid && i_q_full;
    assign accept   = i_valid && !o_stall;
    assign o_q_push = r_stg_valid && !i_q_full;

    // Hand the staged byte on with the outgoing byte from history
    always_comb begin
        o_item          = r_stg;
        o_item.old_byte = ram_rdata;
    end

    // Classify the incoming byte against the running document state
    always_comb begin
        bs_eff   = i_doc_start ? '0 : r_bs;
        hp_eff   = i_doc_start ? '0 : r_hp;
        line_eff = i_doc_start ? LINE_ONE : r_line;
        fill     = (bs_eff < i_kgram_len);

        old_sum = AW'(hp_eff) + AW'(MAX_KGRAM) - AW'(i_kgram_len);
        if (old_sum >= AW'(MAX_KGRAM)) begin
            old_addr = HPW'(old_sum - AW'(MAX_KGRAM));
        end else begin
            old_addr = HPW'(old_sum);
        end

        n_bs        = r_bs;
        n_hp        = r_hp;
        n_line      = r_line;
        n_stg_valid = r_stg_valid;
        n_stg       = r_stg;
        if (o_q_push) begin
            n_stg_valid = 1'b0;
        end
        if (accept) begin
            n_stg_valid = 1'b1;
            n_bs        = fill ? bs_eff + KW'(1) : bs_eff;
            n_hp        = (hp_eff == HPW'(MAX_KGRAM - 1)) ? '0 : hp_eff + HPW'(1);
            n_line      = (i_text_byte == NEWLINE && line_eff != LINE_MAX) ?
                          line_eff + LINE_W'(1) : line_eff;
            n_stg.line_no     = n_line;
            n_stg.doc_start   = i_doc_start;
            n_stg.fill        = fill;
            n_stg.hash_valid  = !fill || (bs_eff + KW'(1) == i_kgram_len);
            n_stg.text_byte   = i_text_byte;
            n_stg.old_byte    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs        <= '0;
            r_hp        <= '0;
            r_line      <= LINE_ONE;
            r_stg_valid <= 1'b0;
        end else begin
            r_bs        <= n_bs;
            r_hp        <= n_hp;
            r_line      <= n_line;
            r_stg_valid <= n_stg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg <= n_stg;
    end

    // Byte history: fetch the byte leaving the k-gram, store the new one
    wfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_KGRAM)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (hp_eff),
        .i_wdata (i_text_byte),
        .i_re    (accept),
        .i_raddr (old_addr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: hdl/wfp_back.sv
module wfp_back #(
    parameter int MAX_WINDOW = wfp_pkg::MAX_WINDOW_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    output logic                               o_q_pop,
    input  wfp_pkg::t_item                     i_item,
    input  logic [$clog2(MAX_WINDOW + 1)-1:0]  i_window_len,
    input  logic [wfp_pkg::HASH_W-1:0]         i_drop_weight,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [wfp_pkg::HASH_W-1:0]         o_fingerprint,
    output logic [wfp_pkg::LINE_W-1:0]         o_line_number
);

    import wfp_pkg::*;

    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int PRODW = 32 + RECIP_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_QUO  = 6'b000010,
        ST_REM  = 6'b000100,
        ST_RED  = 6'b001000,
        ST_WIN  = 6'b010000,
        ST_SCAN = 6'b100000
    } t_state;

    t_state              r_state;
    t_item               r_item;
    logic [31:0]         r_v;
    logic [QUO_W-1:0]    r_q;
    logic [REM_W-1:0]    r_rem;
    logic [HASH_W-1:0]   r_hash;
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_mp;
    logic [MAX_WINDOW-1:0] r_wvalid;
    logic [PW-1:0]       r_sidx;
    logic [WW-1:0]       r_scnt;
    logic [HASH_W-1:0]   r_best;
    logic [PW-1:0]       r_bpos;
    logic                r_out_valid;
    logic [HASH_W-1:0]   r_fp;
    logic [LINE_W-1:0]   r_line;

    t_state              n_state;
    logic [HASH_W-1:0]   n_hash;
    logic [PW-1:0]       n_wp;
    logic [PW-1:0]       n_mp;
    logic [MAX_WINDOW-1:0] n_wvalid;
    logic [PW-1:0]       n_sidx;
    logic [WW-1:0]       n_scnt;
    logic [HASH_W-1:0]   n_best;
    logic [PW-1:0]       n_bpos;
    logic                n_out_valid;

    logic [HASH_W-1:0]   hash_eff;
    logic [31:0]         sub;
    logic [31:0]         v_n;
    logic [PRODW-1:0]    prod;
    logic [31:0]         qm;
    logic [HASH_W-1:0]   h_red;
    logic                wp_over;
    logic                mp_over;
    logic [PW-1:0]       wp_inc;
    logic [PW-1:0]       sidx_inc;
    logic [HASH_W-1:0]   win_val;
    logic [HASH_W-1:0]   scan_val;
    logic                take;
    logic [HASH_W-1:0]   best_n;
    logic [PW-1:0]       bpos_n;
    logic                out_free;
    logic                emit;
    logic [HASH_W-1:0]   emit_val;

    logic                ram_we;
    logic [PW-1:0]       ram_waddr;
    logic                ram_re;
    logic [PW-1:0]       ram_raddr;
    logic [HASH_W-1:0]   ram_rdata;

    assign o_valid       = r_out_valid;
    assign o_fingerprint = r_fp;
    assign o_line_number = r_line;
    assign out_free      = !r_out_valid || !i_stall;

    // Hash datapath: roll, estimate quotient, take remainder, final correction
    always_comb begin
        hash_eff = i_item.doc_start ? '0 : r_hash;
        sub      = i_item.fill ? '0 : 32'(i_item.old_byte) * 32'(i_drop_weight);
        v_n      = 32'(hash_eff) * HASH_BASE + 32'(i_item.text_byte) + SUB_BIAS - sub;
        prod     = PRODW'(r_v) * PRODW'(HASH_RECIP);
        qm       = 32'(r_q) * 32'(HASH_MOD);
        if (r_rem >= REM_W'(HASH_MOD)) begin
            h_red = HASH_W'(r_rem - REM_W'(HASH_MOD));
        end else begin
            h_red = r_rem[HASH_W-1:0];
        end
    end

    // Window pointer arithmetic and compare of the scan step
    always_comb begin
        wp_over  = (WW'(r_wp) >= i_window_len);
        mp_over  = (WW'(r_mp) >= i_window_len);
        wp_inc   = (WW'(r_wp) + WW'(1) == i_window_len) ? '0 : r_wp + PW'(1);
        sidx_inc = (WW'(r_sidx) + WW'(1) == i_window_len) ? '0 : r_sidx + PW'(1);
        win_val  = r_wvalid[r_mp] ? ram_rdata : HASH_NONE;
        scan_val = r_wvalid[r_sidx] ? ram_rdata : HASH_NONE;
        take     = (scan_val <= r_best);
        best_n   = take ? scan_val : r_best;
        bpos_n   = take ? r_sidx : r_bpos;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_hash    = r_hash;
        n_wp      = r_wp;
        n_mp      = r_mp;
        n_wvalid  = r_wvalid;
        n_sidx    = r_sidx;
        n_scnt    = r_scnt;
        n_best    = r_best;
        n_bpos    = r_bpos;
        o_q_pop   = 1'b0;
        emit      = 1'b0;
        emit_val  = r_hash;
        ram_we    = 1'b0;
        ram_waddr = wp_inc;
        ram_re    = 1'b0;
        ram_raddr = r_mp;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = ST_QUO;
                    if (i_item.doc_start) begin
                        n_wp     = '0;
                        n_mp     = '0;
                        n_wvalid = '0;
                    end
                end
            end
            ST_QUO: begin
                n_state = ST_REM;
            end
            ST_REM: begin
                n_state = ST_RED;
            end
            ST_RED: begin
                n_hash = h_red;
                if (!r_item.hash_valid) begin
                    n_state = ST_IDLE;
                end else if (wp_over || mp_over) begin
                    // Fold pointers left beyond a shortened window
                    if (wp_over) begin
                        n_wp = PW'(WW'(r_wp) - i_window_len);
                    end
                    if (mp_over) begin
                        n_mp = PW'(WW'(r_mp) - i_window_len);
                    end
                end else begin
                    ram_we           = 1'b1;
                    ram_waddr        = wp_inc;
                    n_wvalid[wp_inc] = 1'b1;
                    ram_re           = 1'b1;
                    ram_raddr        = r_mp;
                    n_wp             = wp_inc;
                    n_state          = ST_WIN;
                end
            end
            ST_WIN: begin
                if (r_mp == r_wp) begin
                    // Minimum was overwritten: rescan from the oldest entry
                    ram_re    = 1'b1;
                    ram_raddr = wp_inc;
                    n_sidx    = wp_inc;
                    n_scnt    = i_window_len;
                    n_best    = HASH_NONE;
                    n_state   = ST_SCAN;
                end else if (r_hash <= win_val) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        emit_val = r_hash;
                        n_mp     = r_wp;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_scnt == WW'(1)) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        emit_val = best_n;
                        n_mp     = bpos_n;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_best    = best_n;
                    n_bpos    = bpos_n;
                    n_sidx    = sidx_inc;
                    ram_re    = 1'b1;
                    ram_raddr = sidx_inc;
                    n_scnt    = r_scnt - WW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hash      <= '0;
            r_wp        <= '0;
            r_mp        <= '0;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_wp        <= n_wp;
            r_mp        <= n_mp;
            r_wvalid    <= n_wvalid;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_item;
            r_v    <= v_n;
        end
        r_q    <= prod[RECIP_SHIFT +: QUO_W];
        r_rem  <= REM_W'(r_v - qm);
        r_sidx <= n_sidx;
        r_scnt <= n_scnt;
        r_best <= n_best;
        r_bpos <= n_bpos;
        if (emit) begin
            r_fp   <= emit_val;
            r_line <= r_item.line_no;
        end
    end

    // Window of hashes; entries without a valid bit read as empty
    wfp_ram #(
        .WIDTH (HASH_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (h_red),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: hdl/winnowing_fingerprint.sv
// Winnowing fingerprint generator, one document byte per transaction.
// Input channel (i_valid / o_stall): i_text_byte with i_doc_start, which
// restarts hash, window, byte count and line number ahead of that byte.
// Output channel (o_valid / i_stall): o_fingerprint with o_line_number,
// zero or one transaction per input byte, in input order.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): i_cfg_index
// selects k-gram length, window length or drop weight; write while idle.
// The back end handles one byte at a time: a byte still filling the first
// k-gram passes its pop, quotient, remainder and reduction states, a hashing
// byte then also the window compare, and the window is rescanned entry by
// entry when its minimum is overwritten. The modular reduction chain (two
// multiplies and a correction) and the single read port of the window RAM
// set this sequence. After the window is shortened, the next hashing byte
// first folds its pointers back into range. A two-entry queue lets the front
// keep taking bytes while the back end works; o_stall rises when it fills.
// A stalled result holds in the output register; the back end continues
// until it has a further result to present. Reset restores the register
// defaults and an empty document, and needs no clearing pass.
module winnowing_fingerprint #(
    parameter int MAX_KGRAM  = wfp_pkg::MAX_KGRAM_DEF,
    parameter int MAX_WINDOW = wfp_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [wfp_pkg::BYTE_W-1:0]      i_text_byte,
    input  logic                            i_doc_start,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [wfp_pkg::HASH_W-1:0]      o_fingerprint,
    output logic [wfp_pkg::LINE_W-1:0]      o_line_number,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wfp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import wfp_pkg::*;

    localparam int KW = $clog2(MAX_KGRAM + 1);
    localparam int WW = $clog2(MAX_WINDOW + 1);

    logic [CFG_LEN_W-1:0] r_kgram_len;
    logic [CFG_LEN_W-1:0] r_window_len;
    logic [HASH_W-1:0]    r_drop_weight;

    logic [KW-1:0]        kgram_eff;
    logic [WW-1:0]        window_eff;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    t_item                q_in;
    t_item                q_out;

    assign o_cfg_ready = 1'b1;

    // Register writes; drop weight is kept reduced below the modulus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kgram_len   <= KGRAM_RESET;
            r_window_len  <= WINDOW_RESET;
            r_drop_weight <= DROP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KGRAM_LEN: begin
                    r_kgram_len <= i_cfg_data[CFG_LEN_W-1:0];
                end
                CFG_WINDOW_LEN: begin
                    r_window_len <= i_cfg_data[CFG_LEN_W-1:0];
                end
                CFG_DROP_WEIGHT: begin
                    r_drop_weight <= (i_cfg_data >= HASH_MOD) ?
                                     i_cfg_data - HASH_MOD : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp lengths into their supported range
    always_comb begin
        if (r_kgram_len == '0) begin
            kgram_eff = KW'(1);
        end else if (int'(r_kgram_len) > MAX_KGRAM) begin
            kgram_eff = KW'(MAX_KGRAM);
        end else begin
            kgram_eff = KW'(r_kgram_len);
        end

        if (r_window_len == '0) begin
            window_eff = WW'(1);
        end else if (int'(r_window_len) > MAX_WINDOW) begin
            window_eff = WW'(MAX_WINDOW);
        end else begin
            window_eff = WW'(r_window_len);
        end
    end

    wfp_front #(
        .MAX_KGRAM (MAX_KGRAM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_byte (i_text_byte),
        .i_doc_start (i_doc_start),
        .i_kgram_len (kgram_eff),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_item      (q_in)
    );

    wfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    wfp_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .i_item        (q_out),
        .i_window_len  (window_eff),
        .i_drop_weight (r_drop_weight),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fingerprint (o_fingerprint),
        .o_line_number (o_line_number)
    );

endmodule
